// ===== sv/trm_pkg.sv =====
// ----------------------------------------------------------------------------
// trm_pkg: shared types and constants for the battery trimmed-mean filter
// Sample width, scale register limits, decivolt reciprocal and FSM states.
// ----------------------------------------------------------------------------
`default_nettype none

package trm_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SCALE_W  = 17;
    localparam int MV_W     = 17;
    localparam int DV_W     = 10;
    localparam int HELD_W   = 4;

    localparam logic [SCALE_W-1:0] SCALE_MIN   = 17'd65100;
    localparam logic [SCALE_W-1:0] SCALE_MAX   = 17'd73500;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 17'd69300;

    // Millivolts carry a 12-bit fraction shift after the scale multiply.
    localparam int MV_SHIFT = 12;

    // mv / 100 == (mv * 83887) >> 23 for every mv below 91180.
    localparam logic [MV_W-1:0] DECI_RECIP = 17'd83887;
    localparam int              DECI_SHIFT = 23;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_TRIM  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_DEC   = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

// ===== sv/trm_ram.sv =====
// ----------------------------------------------------------------------------
// trm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module trm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 10
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/trm_div.sv =====
// ----------------------------------------------------------------------------
// trm_div: iterative restoring divider
// One quotient bit per cycle; done pulses in the same cycle as the final quotient appears.
// ----------------------------------------------------------------------------
`default_nettype none

module trm_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 4
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              start,
    input  wire  [NUM_W-1:0] dividend,
    input  wire  [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;

    logic [DEN_W:0]    trial;
    logic              fits;
    logic [DEN_W:0]    diff;
    logic [DEN_W-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        fits     = trial >= {1'b0, den_reg};
        diff     = trial - {1'b0, den_reg};
        // without a subtract the trial is below the divisor and fits DEN_W bits
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== sv/battery_voltage_trimmed_mean_filter_core.sv =====
// ----------------------------------------------------------------------------
// battery_voltage_trimmed_mean_filter_core: trimmed-mean battery ADC filter
// Ring of ADC samples in RAM, pass-through, mean or trimmed mean, scaling to mV and dV.
// ----------------------------------------------------------------------------
// Each accepted sample is written into a RING_DEPTH-entry ring RAM. While
// fewer than MIN_FOR_MEAN samples are held the sample is passed through; the
// result is registered through the S_MUL and S_DEC states into the output
// register, S_DEC waiting until the output is free. Otherwise the stored
// entries are read back one per cycle (the single RAM read port sets this),
// summed and tracked for min/max, then divided by an iterative divider that
// produces one quotient bit per cycle; the sum is SUM_W bits wide, 16 for the
// default ten-entry ring. One item is processed at a time; a finished result
// waits in the output register while the next sample is already taken in.
// The scale register may be written at any time the block is idle; values
// outside 65100..73500 are ignored.
`default_nettype none

module battery_voltage_trimmed_mean_filter_core #(
    parameter int RING_DEPTH   = 10,
    parameter int MIN_FOR_MEAN = 3
) (
    input  wire                             clk,
    input  wire                             rst_n,

    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [trm_pkg::SCALE_W-1:0]     cfg_data,

    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire  [trm_pkg::SAMPLE_W-1:0]    raw_sample,

    output logic                            out_valid,
    input  wire                             out_ready,
    output logic [trm_pkg::SAMPLE_W-1:0]    filtered_sample,
    output logic [trm_pkg::MV_W-1:0]        battery_millivolts,
    output logic [trm_pkg::DV_W-1:0]        battery_decivolts,
    output logic [trm_pkg::HELD_W-1:0]      samples_held
);

    localparam int SW     = trm_pkg::SAMPLE_W;
    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = SW + $clog2(RING_DEPTH);
    localparam int PROD_W = SW + trm_pkg::SCALE_W;
    localparam int DPRD_W = 2 * trm_pkg::MV_W;

    trm_pkg::state_t state_reg, state_next;

    logic [trm_pkg::SCALE_W-1:0] scale_reg;
    logic [IDX_W-1:0]            wpos_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [IDX_W-1:0]            rd_idx_reg;
    logic                        rvalid_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic [SW-1:0]               min_reg;
    logic [SW-1:0]               max_reg;
    logic [SW-1:0]               filt_reg;
    logic [trm_pkg::MV_W-1:0]    mv_reg;

    logic                        out_valid_reg;
    logic [SW-1:0]               out_filt_reg;
    logic [trm_pkg::MV_W-1:0]    out_mv_reg;
    logic [trm_pkg::DV_W-1:0]    out_dv_reg;
    logic [trm_pkg::HELD_W-1:0]  out_held_reg;

    logic                        in_xfer;
    logic [CNT_W-1:0]            cnt_next;
    logic [IDX_W-1:0]            wpos_next;
    logic                        ring_full;
    logic [SW-1:0]               rdata;
    logic [SUM_W-1:0]            dividend;
    logic [CNT_W-1:0]            divisor;
    logic                        div_start;
    logic                        div_done;
    logic [SUM_W-1:0]            quotient;
    logic                        out_free;
    logic [PROD_W-1:0]           mv_prod;
    logic [DPRD_W-1:0]           dv_prod;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == trm_pkg::S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign ring_full = (cnt_reg == CNT_W'(RING_DEPTH));

    always_comb
    begin
        cnt_next  = (cnt_reg == CNT_W'(RING_DEPTH)) ? cnt_reg : cnt_reg + 1'b1;
        wpos_next = (wpos_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : wpos_reg + 1'b1;
        // drop one min and one max when the ring is full
        dividend  = ring_full ? (sum_reg - SUM_W'(min_reg) - SUM_W'(max_reg)) : sum_reg;
        divisor   = ring_full ? CNT_W'(RING_DEPTH - 2) : cnt_reg;
        div_start = (state_reg == trm_pkg::S_TRIM);
        mv_prod   = PROD_W'(filt_reg) * PROD_W'(scale_reg);
        dv_prod   = DPRD_W'(mv_reg) * DPRD_W'(trm_pkg::DECI_RECIP);
    end

    trm_ram #(
        .WIDTH (SW),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (in_xfer),
        .waddr (wpos_reg),
        .wdata (raw_sample),
        .raddr (rd_idx_reg),
        .rdata (rdata)
    );

    trm_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            trm_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (cnt_next < CNT_W'(MIN_FOR_MEAN)) ? trm_pkg::S_MUL
                                                                   : trm_pkg::S_SCAN;
                end
            end
            trm_pkg::S_SCAN:
            begin
                if (rd_idx_reg == IDX_W'(cnt_reg - 1'b1))
                begin
                    state_next = trm_pkg::S_DRAIN;
                end
            end
            trm_pkg::S_DRAIN: state_next = trm_pkg::S_TRIM;
            trm_pkg::S_TRIM:  state_next = trm_pkg::S_DIV;
            trm_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = trm_pkg::S_MUL;
                end
            end
            trm_pkg::S_MUL:   state_next = trm_pkg::S_DEC;
            trm_pkg::S_DEC:
            begin
                if (out_free)
                begin
                    state_next = trm_pkg::S_IDLE;
                end
            end
            default:          state_next = trm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= trm_pkg::S_IDLE;
            scale_reg     <= trm_pkg::SCALE_RESET;
            wpos_reg      <= '0;
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rvalid_reg <= (state_reg == trm_pkg::S_SCAN);

            if (cfg_valid && cfg_ready
                && cfg_data >= trm_pkg::SCALE_MIN && cfg_data <= trm_pkg::SCALE_MAX)
            begin
                scale_reg <= cfg_data;
            end

            if (in_xfer)
            begin
                wpos_reg   <= wpos_next;
                cnt_reg    <= cnt_next;
                rd_idx_reg <= '0;
            end
            else if (state_reg == trm_pkg::S_SCAN)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end

            if (state_reg == trm_pkg::S_DEC && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sum_reg  <= '0;
            min_reg  <= '1;
            max_reg  <= '0;
            filt_reg <= raw_sample;
        end
        else if (rvalid_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(rdata);
            if (rdata < min_reg)
            begin
                min_reg <= rdata;
            end
            if (rdata > max_reg)
            begin
                max_reg <= rdata;
            end
        end
        else if (state_reg == trm_pkg::S_DIV && div_done)
        begin
            filt_reg <= quotient[SW-1:0];
        end

        if (state_reg == trm_pkg::S_MUL)
        begin
            mv_reg <= mv_prod[trm_pkg::MV_SHIFT +: trm_pkg::MV_W];
        end

        if (state_reg == trm_pkg::S_DEC && out_free)
        begin
            out_filt_reg <= filt_reg;
            out_mv_reg   <= mv_reg;
            out_dv_reg   <= dv_prod[trm_pkg::DECI_SHIFT +: trm_pkg::DV_W];
            out_held_reg <= trm_pkg::HELD_W'(cnt_reg);
        end
    end

    assign out_valid          = out_valid_reg;
    assign filtered_sample    = out_filt_reg;
    assign battery_millivolts = out_mv_reg;
    assign battery_decivolts  = out_dv_reg;
    assign samples_held       = out_held_reg;

endmodule

`default_nettype wire
